// ===== src/mh_pkg.sv =====
// Shared types, constants and the arctangent table of the heading pipeline.
// Used by every module of magnetometer_heading; depends on nothing.
`default_nettype none
package mh_pkg;

  localparam int SAMPLE_W      = 16;
  localparam int DECL_W        = 14;
  localparam int ANGLE_W       = 15;
  localparam int VEC_W         = 44;   // sample scaled by 2^24 plus CORDIC growth
  localparam int ACC_W         = 32;   // angle in 2^-16 of 1/64 degree
  localparam int INPUT_SHIFT   = 24;
  localparam int FINE_BITS     = 16;
  localparam int COARSE_W      = ACC_W + 1 - FINE_BITS;  // rounded angle width
  localparam int WRAP_W        = COARSE_W + 1;           // after declination
  localparam int TABLE_LEN     = 24;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int DECL_RESET    = 544;
  localparam int FULL_TURN     = 23040;

  localparam logic signed [ACC_W-1:0] HALF_TURN_FINE = 32'sd754974720;

  typedef struct packed {
    logic                    zero;
    logic signed [VEC_W-1:0] re;
    logic signed [VEC_W-1:0] im;
    logic signed [ACC_W-1:0] acc;
  } mh_vec_t;

  // atan(2^-i) in 2^-16 of 1/64 degree.
  function automatic logic signed [ACC_W-1:0] mh_atan(input int idx);
    logic signed [ACC_W-1:0] a;
    a = '0;
    case (idx)
      0:  a = 32'sd188743680;
      1:  a = 32'sd111421900;
      2:  a = 32'sd58872272;
      3:  a = 32'sd29884485;
      4:  a = 32'sd15000234;
      5:  a = 32'sd7507429;
      6:  a = 32'sd3754631;
      7:  a = 32'sd1877430;
      8:  a = 32'sd938729;
      9:  a = 32'sd469366;
      10: a = 32'sd234683;
      11: a = 32'sd117342;
      12: a = 32'sd58671;
      13: a = 32'sd29335;
      14: a = 32'sd14668;
      15: a = 32'sd7334;
      16: a = 32'sd3667;
      17: a = 32'sd1833;
      18: a = 32'sd917;
      19: a = 32'sd458;
      20: a = 32'sd229;
      21: a = 32'sd115;
      22: a = 32'sd57;
      23: a = 32'sd29;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

// ===== src/mh_prep.sv =====
// Input stage: scales a sample pair and folds the left half plane by a half turn.
// Depends on mh_pkg.
`default_nettype none
module mh_prep (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              en,
  input  wire logic                              in_valid,
  input  wire logic signed [mh_pkg::SAMPLE_W-1:0] x_sample,
  input  wire logic signed [mh_pkg::SAMPLE_W-1:0] y_sample,
  output logic                                   valid_r,
  output mh_pkg::mh_vec_t                        vec_r
);
  import mh_pkg::*;

  logic signed [VEC_W-1:0] re_s;
  logic signed [VEC_W-1:0] im_s;
  mh_vec_t                 vec_nxt;
  logic                    valid_nxt;

  assign re_s = VEC_W'(y_sample) <<< INPUT_SHIFT;
  assign im_s = VEC_W'(x_sample) <<< INPUT_SHIFT;

  always_comb begin
    vec_nxt.zero = (x_sample == '0) && (y_sample == '0);
    if (y_sample < 0) begin
      vec_nxt.acc = (x_sample >= 0) ? HALF_TURN_FINE : -HALF_TURN_FINE;
      vec_nxt.re  = -re_s;
      vec_nxt.im  = -im_s;
    end else begin
      vec_nxt.acc = '0;
      vec_nxt.re  = re_s;
      vec_nxt.im  = im_s;
    end
  end

  assign valid_nxt = en ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vec_r <= vec_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/mh_cell.sv =====
// One CORDIC micro-rotation with its own register; cells are chained in the top level.
// Depends on mh_pkg.
`default_nettype none
module mh_cell #(
  parameter int STAGE = 0
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire logic            in_valid,
  input  wire mh_pkg::mh_vec_t in_vec,
  output logic                 valid_r,
  output mh_pkg::mh_vec_t      vec_r
);
  import mh_pkg::*;

  localparam logic signed [ACC_W-1:0] ATAN = mh_atan(STAGE);

  logic signed [VEC_W-1:0] re_in;
  logic signed [VEC_W-1:0] im_in;
  logic signed [VEC_W-1:0] dr;
  logic signed [VEC_W-1:0] di;
  mh_vec_t                 vec_nxt;
  logic                    valid_nxt;

  assign re_in = in_vec.re;
  assign im_in = in_vec.im;
  assign dr    = im_in >>> STAGE;
  assign di    = re_in >>> STAGE;

  always_comb begin
    vec_nxt.zero = in_vec.zero;
    if (im_in >= 0) begin
      vec_nxt.re  = re_in + dr;
      vec_nxt.im  = im_in - di;
      vec_nxt.acc = in_vec.acc + ATAN;
    end else begin
      vec_nxt.re  = re_in - dr;
      vec_nxt.im  = im_in + di;
      vec_nxt.acc = in_vec.acc - ATAN;
    end
  end

  assign valid_nxt = en ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vec_r <= vec_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/mh_wrap.sv =====
// Output stage: rounds the angle, subtracts the declination, wraps into one turn.
// Holds the output register. Depends on mh_pkg.
`default_nettype none
module mh_wrap (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             en,
  input  wire logic                             in_valid,
  input  wire mh_pkg::mh_vec_t                  in_vec,
  input  wire logic signed [mh_pkg::DECL_W-1:0] decl,
  output logic                                  valid_r,
  output logic [mh_pkg::ANGLE_W-1:0]            angle_r
);
  import mh_pkg::*;

  localparam logic signed [WRAP_W-1:0] TURN = WRAP_W'(FULL_TURN);

  logic signed [ACC_W:0]    acc_ext;
  logic signed [ACC_W:0]    rounded;
  logic signed [WRAP_W-1:0] v0;
  logic signed [WRAP_W-1:0] v1;
  logic signed [WRAP_W-1:0] v2;
  logic signed [WRAP_W-1:0] v3;
  logic [ANGLE_W-1:0]       angle_nxt;
  logic                     valid_nxt;

  // A zero vector has angle 0 whatever the rotations piled up.
  assign acc_ext = in_vec.zero ? '0 : (ACC_W+1)'(in_vec.acc);
  assign rounded = acc_ext + (ACC_W+1)'(1 <<< (FINE_BITS - 1));
  // The part-select is unsigned, so it is made signed before it is widened.
  assign v0 = WRAP_W'(signed'(rounded[ACC_W:FINE_BITS])) - WRAP_W'(decl);

  // The value stays within less than one turn either side of zero.
  assign v1 = (v0 < 0) ? v0 + TURN : v0;
  assign v2 = (v1 < 0) ? v1 + TURN : v1;
  assign v3 = (v2 >= TURN) ? v2 - TURN : v2;
  assign angle_nxt = v3[ANGLE_W-1:0];

  assign valid_nxt = en ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle_r <= angle_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/magnetometer_heading.sv =====
// Top level of the compass heading pipeline: configuration register, input stage,
// CORDIC cell chain and output stage. Depends on mh_pkg, mh_prep, mh_cell, mh_wrap.
`default_nettype none
// The block accepts one X/Y sample per clock while the output is not stalled and
// returns one heading per sample, atan2(x, y) minus the declination register, in
// 1/64 degree from 0 to 23039. Every sample passes an input stage, CORDIC_STEPS
// rotation cells and an output stage. The whole chain advances together; it holds
// only while the output register has a result that is not taken. The declination
// register sits at APB address 0 and is applied at the output stage, so it
// should be written only while no sample is in flight.
module magnetometer_heading #(
  parameter int CORDIC_STEPS = mh_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic signed [mh_pkg::SAMPLE_W-1:0] in_x_sample,
  input  wire logic signed [mh_pkg::SAMPLE_W-1:0] in_y_sample,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [mh_pkg::ANGLE_W-1:0]              out_heading_angle,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [2:0]                         paddr,
  input  wire logic [31:0]                        pwdata,
  output logic [31:0]                             prdata,
  output logic                                    pready
);
  import mh_pkg::*;

  logic                     en;
  logic signed [DECL_W-1:0] decl_r;
  logic signed [DECL_W-1:0] decl_nxt;
  logic                     cfg_write;
  logic                     stage_valid [CORDIC_STEPS+1];
  mh_vec_t                  stage_vec   [CORDIC_STEPS+1];

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign decl_nxt  = cfg_write ? pwdata[DECL_W-1:0] : decl_r;
  assign prdata    = (paddr[2] == 1'b0) ? 32'(decl_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decl_r <= DECL_W'(DECL_RESET);
    end else begin
      decl_r <= decl_nxt;
    end
  end

  assign en       = out_ready || !out_valid;
  assign in_ready = en;

  mh_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .x_sample (in_x_sample),
    .y_sample (in_y_sample),
    .valid_r  (stage_valid[0]),
    .vec_r    (stage_vec[0])
  );

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    mh_cell #(
      .STAGE (i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_valid (stage_valid[i]),
      .in_vec   (stage_vec[i]),
      .valid_r  (stage_valid[i+1]),
      .vec_r    (stage_vec[i+1])
    );
  end

  mh_wrap u_wrap (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (stage_valid[CORDIC_STEPS]),
    .in_vec   (stage_vec[CORDIC_STEPS]),
    .decl     (decl_r),
    .valid_r  (out_valid),
    .angle_r  (out_heading_angle)
  );

endmodule
`default_nettype wire

// ===== tb/sv/magnetometer_heading_tb.sv =====
// Testbench for magnetometer_heading: drives X/Y samples and the declination register,
// predicts each heading with its own vectoring CORDIC and checks every output transfer.
// Depends on mh_pkg and the magnetometer_heading RTL only.
module magnetometer_heading_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mh_pkg::*;

  localparam int          PIPE_LATENCY = CORDIC_STEPS_DEF + 2;
  localparam int          LIMIT_CYCLES = 400000;
  localparam int          STALL_CYCLES = 300;
  localparam logic [2:0]  DECL_ADDR    = 3'd0;
  localparam logic [2:0]  SPARE_ADDR   = 3'd4;
  localparam longint      ONE_TURN     = longint'(FULL_TURN) <<< FINE_BITS;
  localparam longint      HALF_TURN    = longint'(FULL_TURN / 2) <<< FINE_BITS;

  // atan(2^-i) in 2^-16 of 1/64 degree.
  localparam longint ATAN_FINE [TABLE_LEN] = '{
    188743680, 111421900, 58872272, 29884485, 15000234, 7507429,
    3754631, 1877430, 938729, 469366, 234683, 117342,
    58671, 29335, 14668, 7334, 3667, 1833,
    917, 458, 229, 115, 57, 29
  };

  typedef struct {
    logic signed [SAMPLE_W-1:0] x;
    logic signed [SAMPLE_W-1:0] y;
    logic [ANGLE_W-1:0]         heading;
  } heading_expect_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic signed [SAMPLE_W-1:0]  in_x_sample = '0;
  logic signed [SAMPLE_W-1:0]  in_y_sample = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [ANGLE_W-1:0]          out_heading_angle;
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [2:0]                  paddr = '0;
  logic [31:0]                 pwdata = '0;
  logic [31:0]                 prdata;
  logic                        pready;

  heading_expect_t             pending_headings[$];
  logic signed [DECL_W-1:0]    declination = DECL_W'(DECL_RESET);
  int                          send_idle_pct = 0;
  int                          recv_idle_pct = 0;
  int                          stall_left = 0;
  int                          error_count = 0;
  int                          samples_sent = 0;
  int                          headings_checked = 0;
  int                          decl_writes = 0;
  int                          cycle_count = 0;

  magnetometer_heading dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_x_sample       (in_x_sample),
    .in_y_sample       (in_y_sample),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_heading_angle (out_heading_angle),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Timed out after %0d cycles with %0d headings outstanding.",
               cycle_count, pending_headings.size());
      $display("magnetometer_heading_tb: FAIL");
      $finish;
    end
  end

  // Heading of one sample: atan2(x, y) by vectoring CORDIC, minus the declination,
  // rounded half up and wrapped into one turn.
  function automatic logic [ANGLE_W-1:0] predict_heading(
    input logic signed [SAMPLE_W-1:0] x,
    input logic signed [SAMPLE_W-1:0] y,
    input logic signed [DECL_W-1:0]   decl
  );
    longint re;
    longint im;
    longint acc;
    longint dr;
    longint di;
    longint fine;
    longint rounded;
    acc = 0;
    re  = longint'(y) <<< INPUT_SHIFT;
    im  = longint'(x) <<< INPUT_SHIFT;
    if (x != 0 || y != 0) begin
      // A vector in the left half plane is turned by a half turn first.
      if (re < 0) begin
        acc = (im >= 0) ? HALF_TURN : -HALF_TURN;
        re  = -re;
        im  = -im;
      end
      for (int i = 0; i < CORDIC_STEPS_DEF && i < TABLE_LEN; i++) begin
        dr = im >>> i;
        di = re >>> i;
        if (im >= 0) begin
          re  = re + dr;
          im  = im - di;
          acc = acc + ATAN_FINE[i];
        end else begin
          re  = re - dr;
          im  = im + di;
          acc = acc - ATAN_FINE[i];
        end
      end
    end
    fine    = acc - (longint'(decl) <<< FINE_BITS) + 4 * ONE_TURN;
    rounded = (fine + (longint'(1) <<< (FINE_BITS - 1))) >>> FINE_BITS;
    return ANGLE_W'(rounded % FULL_TURN);
  endfunction

  // Output side: random or long stalls, counted here, then the check of each transfer.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : check_heading
    heading_expect_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_headings.size() == 0) begin
        $error("heading_angle: no heading expected, got %0d", out_heading_angle);
        error_count++;
      end else begin
        want = pending_headings.pop_front();
        headings_checked++;
        if (out_heading_angle !== want.heading) begin
          $error("heading_angle: expected %0d, actual %0d (x=%0d y=%0d)",
                 want.heading, out_heading_angle, want.x, want.y);
          error_count++;
        end
      end
    end
  end

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] x,
                             input logic signed [SAMPLE_W-1:0] y);
    heading_expect_t item;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_x_sample <= x;
    in_y_sample <= y;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    item.x       = x;
    item.y       = y;
    item.heading = predict_heading(x, y, declination);
    pending_headings.push_back(item);
    samples_sent++;
  endtask

  // Drops valid and waits until every expected heading has been taken.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_headings.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == DECL_ADDR) begin
      declination = data[DECL_W-1:0];
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // The register is applied at the output stage, so the pipeline must be empty.
  task automatic set_declination(input logic signed [DECL_W-1:0] value);
    wait_drained();
    repeat (PIPE_LATENCY + 2) @(posedge clk);
    write_register(DECL_ADDR, {{(32 - DECL_W){value[DECL_W-1]}}, value});
    decl_writes++;
  endtask

  function automatic logic signed [SAMPLE_W-1:0] random_word(input int spread);
    if (spread == 0) begin
      return SAMPLE_W'($urandom);
    end
    return SAMPLE_W'(int'($urandom_range(2 * spread)) - spread);
  endfunction

  task automatic test_reset_declination();
    send_sample(16'sd0, 16'sd0);
    send_sample(16'sd0, 16'sd1000);
    send_sample(16'sd1000, 16'sd0);
    wait_drained();
  endtask

  task automatic test_vector_extremes();
    send_sample(16'sd32767, 16'sd0);
    send_sample(-16'sd32768, 16'sd0);
    send_sample(16'sd0, 16'sd32767);
    send_sample(16'sd0, -16'sd32768);
    send_sample(16'sd32767, 16'sd32767);
    send_sample(-16'sd32768, -16'sd32768);
    send_sample(-16'sd32768, 16'sd32767);
    send_sample(16'sd32767, -16'sd32768);
    // Negative Y with zero or small X exercises the half-turn pre-rotation; the last sample has Y at zero.
    send_sample(16'sd0, -16'sd1);
    send_sample(16'sd1, -16'sd1);
    send_sample(-16'sd1, -16'sd1);
    send_sample(-16'sd1, 16'sd0);
    wait_drained();
  endtask

  task automatic test_declination_extremes();
    logic signed [DECL_W-1:0] corners [5];
    corners = '{DECL_W'(0), DECL_W'(-5760), DECL_W'(5760), DECL_W'(-8192), DECL_W'(8191)};
    foreach (corners[i]) begin
      set_declination(corners[i]);
      send_sample(16'sd0, 16'sd0);
      // Just below zero degrees, which rounds up to zero before the declination is taken off.
      send_sample(-16'sd1, 16'sd32767);
    end
    wait_drained();
  endtask

  task automatic test_spare_register();
    wait_drained();
    write_register(SPARE_ADDR, 32'h0000_1555);
    send_sample(16'sd300, -16'sd200);
    wait_drained();
  endtask

  // The output holds off for a long stretch while samples keep coming, so the
  // pipeline fills and input transfers stall.
  task automatic test_output_stall();
    send_idle_pct = 0;
    @(posedge clk);
    stall_left = STALL_CYCLES;
    for (int i = 0; i < 60; i++) begin
      send_sample(random_word(0), random_word(0));
    end
    wait_drained();
    for (int i = 0; i < 10; i++) begin
      send_sample(random_word(0), random_word(0));
    end
    wait_drained();
  endtask

  task automatic test_random_traffic(input int count, input int send_pct, input int recv_pct,
                                     input logic signed [DECL_W-1:0] decl);
    int kind;
    set_declination(decl);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(9);
      if (kind < 6) begin
        send_sample(random_word(0), random_word(0));
      end else if (kind < 8) begin
        send_sample(random_word(8), random_word(8));
      end else if (kind == 8) begin
        send_sample(random_word(0), random_word(3));
      end else begin
        send_sample(random_word(3), random_word(0));
      end
    end
    wait_drained();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 14;
    recv_idle_pct = 67;
    test_reset_declination();
    test_vector_extremes();
    test_declination_extremes();
    test_spare_register();
    test_output_stall();

    test_random_traffic(500, 14, 67, DECL_W'($urandom));
    test_random_traffic(500, 67, 14, DECL_W'(int'($urandom_range(11520)) - 5760));
    test_random_traffic(400, 0, 0, DECL_W'(DECL_RESET));

    wait_drained();
    repeat (PIPE_LATENCY + 8) @(posedge clk);
    if (pending_headings.size() != 0) begin
      $error("heading_angle: %0d expected headings never arrived", pending_headings.size());
      error_count++;
    end
    $display("Sent %0d samples under %0d declination writes; checked %0d headings.",
             samples_sent, decl_writes, headings_checked);
    $display("Traffic included a %0d-cycle output stall and both idle patterns.", STALL_CYCLES);
    if (error_count == 0) begin
      $display("magnetometer_heading_tb: PASS");
    end else begin
      $display("magnetometer_heading_tb: FAIL");
    end
    $finish;
  end

endmodule
